// ===== sv/cdrf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cdrf_pkg;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS = 48;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_CHUNK_SIZE = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_REGION_BASE = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MATCH_MODE = 2'd2;

	localparam int CHUNK_SIZE_BITS = 25;
	localparam int CHUNK_POS_BITS = 24;
	localparam int BASE_BITS = 48;
	localparam int START_BITS = 48;
	localparam int LENGTH_BITS = 40;

	localparam logic [CHUNK_SIZE_BITS-1:0] CHUNK_SIZE_RESET = 25'd4096;
	localparam logic [CHUNK_SIZE_BITS-1:0] CHUNK_MAX = 25'd16777216;
	localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = '1;

	typedef struct packed {
		logic [7:0] first_byte;
		logic [7:0] second_byte;
		logic       final_byte;
	} in_word_t;

	typedef struct packed {
		logic [START_BITS-1:0]  run_start;
		logic [LENGTH_BITS-1:0] run_length;
	} out_word_t;

	typedef struct packed {
		logic [CHUNK_SIZE_BITS-1:0] chunk_size;
		logic [BASE_BITS-1:0]       region_base;
		logic                       match_mode;
	} cfg_t;

endpackage

`default_nettype wire

// ===== sv/cdrf_cfg_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cdrf_cfg_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [cdrf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [cdrf_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	output cdrf_pkg::cfg_t                           cfg
);

	cdrf_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.chunk_size <= cdrf_pkg::CHUNK_SIZE_RESET;
			cfg_q.region_base <= '0;
			cfg_q.match_mode <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				cdrf_pkg::CFG_CHUNK_SIZE: begin
					cfg_q.chunk_size <= cfg_data[cdrf_pkg::CHUNK_SIZE_BITS-1:0];
				end
				cdrf_pkg::CFG_REGION_BASE: begin
					cfg_q.region_base <= cfg_data[cdrf_pkg::BASE_BITS-1:0];
				end
				cdrf_pkg::CFG_MATCH_MODE: begin
					cfg_q.match_mode <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/cdrf_run_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cdrf_run_core #(
	parameter int OFFSET_BITS = 40
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	input  wire logic                                  step,
	input  wire cdrf_pkg::in_word_t                    item,
	input  wire cdrf_pkg::cfg_t                        cfg,
	output logic                                       emit_hit,
	output logic [OFFSET_BITS-1:0]                     emit_offset,
	output logic [cdrf_pkg::LENGTH_BITS-1:0]           emit_length
);

	localparam int CSB = cdrf_pkg::CHUNK_SIZE_BITS;
	localparam int LB = cdrf_pkg::LENGTH_BITS;
	localparam int SW = (OFFSET_BITS + 1 > CSB) ? OFFSET_BITS + 1 : CSB;

	logic [OFFSET_BITS-1:0]             byte_offset_q;
	logic [cdrf_pkg::CHUNK_POS_BITS-1:0] chunk_position_q;
	logic                               chunk_differs_q;
	logic                               run_open_q;
	logic [OFFSET_BITS-1:0]             run_offset_q;
	logic [LB-1:0]                      run_bytes_q;

	logic [CSB-1:0]         size_eff;
	logic [CSB-1:0]         count;
	logic                   differs;
	logic                   close;
	logic                   qual;
	logic                   last;
	logic [OFFSET_BITS-1:0] next_offset;
	logic [SW-1:0]          here_p1_w;
	logic [SW-1:0]          count_w;
	logic [SW-1:0]          start_diff;
	logic [OFFSET_BITS-1:0] open_offset;
	logic [LB:0]            run_sum;
	logic [LB-1:0]          run_sum_sat;
	logic [LB-1:0]          count_len;

	always_comb begin
		if (cfg.chunk_size == '0) begin
			size_eff = CSB'(1);
		end else if (cfg.chunk_size > cdrf_pkg::CHUNK_MAX) begin
			size_eff = cdrf_pkg::CHUNK_MAX;
		end else begin
			size_eff = cfg.chunk_size;
		end
	end

	assign last = item.final_byte;
	assign differs = chunk_differs_q | (item.first_byte != item.second_byte);
	assign count = CSB'(chunk_position_q) + CSB'(1);
	assign close = (count >= size_eff) || last;
	assign qual = cfg.match_mode ? !differs : differs;
	assign next_offset = (byte_offset_q == '1) ? byte_offset_q :
		byte_offset_q + OFFSET_BITS'(1);

	assign here_p1_w = SW'(byte_offset_q) + SW'(1);
	assign count_w = SW'(count);
	assign start_diff = here_p1_w - count_w;
	assign open_offset = (here_p1_w >= count_w) ? start_diff[OFFSET_BITS-1:0] : '0;

	assign count_len = LB'(count);
	assign run_sum = (LB + 1)'(run_bytes_q) + (LB + 1)'(count);
	assign run_sum_sat = run_sum[LB] ? cdrf_pkg::LENGTH_MAX : run_sum[LB-1:0];

	assign emit_hit = close && (qual ? last : run_open_q);
	assign emit_offset = (qual && !run_open_q) ? open_offset : run_offset_q;
	assign emit_length = qual ? (run_open_q ? run_sum_sat : count_len) : run_bytes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_offset_q <= '0;
			chunk_position_q <= '0;
			chunk_differs_q <= 1'b0;
			run_open_q <= 1'b0;
			run_offset_q <= '0;
			run_bytes_q <= '0;
		end else if (step) begin
			if (last) begin
				byte_offset_q <= '0;
				chunk_position_q <= '0;
				chunk_differs_q <= 1'b0;
				run_open_q <= 1'b0;
				run_offset_q <= '0;
				run_bytes_q <= '0;
			end else begin
				byte_offset_q <= next_offset;
				if (close) begin
					chunk_position_q <= '0;
					chunk_differs_q <= 1'b0;
					if (qual) begin
						if (run_open_q) begin
							run_bytes_q <= run_sum_sat;
						end else begin
							run_open_q <= 1'b1;
							run_offset_q <= open_offset;
							run_bytes_q <= count_len;
						end
					end else if (run_open_q) begin
						run_open_q <= 1'b0;
						run_offset_q <= '0;
						run_bytes_q <= '0;
					end
				end else begin
					chunk_position_q <= count[cdrf_pkg::CHUNK_POS_BITS-1:0];
					chunk_differs_q <= differs;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/chunk_diff_run_finder.sv =====
// Snapshot compare and run finder. Byte pairs of two equal-length snapshots
// enter on the in channel (in_valid, in_ready, in_data), one word per byte
// offset, with final_byte set on the last pair. Bytes are grouped into chunks
// of chunk_size; runs of qualifying chunks leave on the out channel as a
// start address and a length in bytes.
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) is
// always ready and must only be written while no stream is in flight.
// There are three register stages: input, run tracking result, and the
// address adder on the output. A word that closes a run shows its result on
// out_data with out_valid high once it has passed through all three.
// Throughput is one word per cycle while the receiver takes results.
// A stalled receiver freezes all three stages; in_ready stays high until the
// input register holds a word that cannot move on.
// Reset clears the stream state, the pipeline and the configuration
// (chunk_size 4096, region_base 0, match_mode 0). After a final byte the
// stream state returns to its reset values, so a new snapshot pair may follow.
`timescale 1ns / 1ps
`default_nettype none

module chunk_diff_run_finder #(
	parameter int OFFSET_BITS = 40,
	parameter int ADDRESS_BITS = 48
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire cdrf_pkg::in_word_t                  in_data,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output cdrf_pkg::out_word_t                      out_data,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [cdrf_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [cdrf_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	localparam int LB = cdrf_pkg::LENGTH_BITS;
	localparam int SUM_BITS = 64;
	localparam logic [SUM_BITS-1:0] ADDR_MASK = (ADDRESS_BITS >= SUM_BITS) ? '1 :
		((SUM_BITS'(1) << ADDRESS_BITS) - SUM_BITS'(1));

	cdrf_pkg::cfg_t     cfg;
	cdrf_pkg::in_word_t item_s1;
	logic               valid_s1;
	logic               en;
	logic               hit;
	logic [OFFSET_BITS-1:0] hit_offset;
	logic [LB-1:0]      hit_length;

	logic                   valid_s2;
	logic [OFFSET_BITS-1:0] offset_s2;
	logic [LB-1:0]          length_s2;
	logic [SUM_BITS-1:0]    start_sum;

	logic                out_valid_q;
	cdrf_pkg::out_word_t out_data_q;

	assign en = !out_valid_q || out_ready;
	assign in_ready = en || !valid_s1;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

	cdrf_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	cdrf_run_core #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_run_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (en && valid_s1),
		.item        (item_s1),
		.cfg         (cfg),
		.emit_hit    (hit),
		.emit_offset (hit_offset),
		.emit_length (hit_length)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				valid_s1 <= in_valid;
			end
			if (en) begin
				valid_s2 <= valid_s1 && hit;
				out_valid_q <= valid_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
		if (en) begin
			offset_s2 <= hit_offset;
			length_s2 <= hit_length;
			out_data_q.run_start <= start_sum[cdrf_pkg::START_BITS-1:0];
			out_data_q.run_length <= length_s2;
		end
	end

	assign start_sum = (SUM_BITS'(cfg.region_base) + SUM_BITS'(offset_s2)) & ADDR_MASK;

endmodule

`default_nettype wire

// ===== sv/cdrf_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cdrf_checker (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                in_ready,
	input wire logic                out_valid,
	input wire logic                out_ready,
	input wire cdrf_pkg::out_word_t out_data,
	input wire logic                cfg_ready
);

	// A result that waits for the receiver keeps its word.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	// Every run covers at least one byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data.run_length != '0)
		else $error("run of zero length");

	// With the output free, the input side must not stall.
	assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) |-> in_ready)
		else $error("input stalled while output is free");

	// Configuration writes are never refused.
	assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("configuration port not ready");

endmodule

bind chunk_diff_run_finder cdrf_checker u_cdrf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data),
	.cfg_ready (cfg_ready)
);

`default_nettype wire

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

	localparam int OFFSET_BITS = 40;
	localparam int ADDRESS_BITS = 48;
	localparam int IDX_W = cdrf_pkg::CFG_INDEX_BITS;
	localparam int DATA_W = cdrf_pkg::CFG_DATA_BITS;
	localparam int SIZE_W = cdrf_pkg::CHUNK_SIZE_BITS;
	localparam int POS_W = cdrf_pkg::CHUNK_POS_BITS;
	localparam int BASE_W = cdrf_pkg::BASE_BITS;
	localparam int LEN_W = cdrf_pkg::LENGTH_BITS;
	localparam logic [63:0] OFFSET_MAX = (64'd1 << OFFSET_BITS) - 64'd1;
	localparam int PIPE_DRAIN = 8;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int TARGET_BYTES = 1610;

	typedef enum int {
		CHUNK_SAME,
		CHUNK_ONE_DIFF,
		CHUNK_MIXED,
		CHUNK_ALL_DIFF
	} chunk_pattern_t;

	typedef enum int {
		STALL_NONE,
		STALL_HALF,
		STALL_RARE,
		STALL_FULL
	} stall_kind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	cdrf_pkg::in_word_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	cdrf_pkg::out_word_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [IDX_W-1:0] cfg_index = cdrf_pkg::CFG_CHUNK_SIZE;
	logic [DATA_W-1:0] cfg_data = '0;

	chunk_diff_run_finder #(
		.OFFSET_BITS(OFFSET_BITS),
		.ADDRESS_BITS(ADDRESS_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	cdrf_pkg::in_word_t pending_bytes[$];
	cdrf_pkg::out_word_t expected_runs[$];
	int bytes_left = 0;
	int bytes_queued = 0;
	int mismatches = 0;
	int quiet_cycles = 0;

	logic [SIZE_W-1:0] chunk_size_q = cdrf_pkg::CHUNK_SIZE_RESET;
	logic [BASE_W-1:0] base_q = '0;
	logic match_q = 1'b0;

	logic [OFFSET_BITS-1:0] byte_off = '0;
	logic [POS_W-1:0] chunk_pos = '0;
	logic chunk_dirty = 1'b0;
	logic run_active = 1'b0;
	logic [OFFSET_BITS-1:0] run_first = '0;
	logic [LEN_W-1:0] run_size = '0;

	task automatic report(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatches++;
	endtask

	task automatic take_byte(input cdrf_pkg::in_word_t w);
		logic [63:0] size, here, count, sum;
		logic qual;
		logic emit;
		cdrf_pkg::out_word_t r;
		size = 64'(chunk_size_q);
		if (size == 64'd0)
			size = 64'd1;
		if (size > 64'(cdrf_pkg::CHUNK_MAX))
			size = 64'(cdrf_pkg::CHUNK_MAX);
		here = 64'(byte_off);
		emit = 1'b0;
		r = '0;
		if (w.first_byte != w.second_byte)
			chunk_dirty = 1'b1;
		count = 64'(chunk_pos) + 64'd1;
		byte_off = OFFSET_BITS'((here < OFFSET_MAX) ? here + 64'd1 : OFFSET_MAX);
		if (count >= size || w.final_byte) begin
			qual = match_q ? !chunk_dirty : chunk_dirty;
			if (qual) begin
				if (run_active) begin
					sum = 64'(run_size) + count;
					run_size = (sum > 64'(cdrf_pkg::LENGTH_MAX)) ? cdrf_pkg::LENGTH_MAX :
						LEN_W'(sum);
				end else begin
					run_active = 1'b1;
					run_first = (here + 64'd1 >= count) ?
						OFFSET_BITS'(here + 64'd1 - count) : '0;
					run_size = LEN_W'(count);
				end
			end else if (run_active) begin
				emit = 1'b1;
				r.run_start = base_q + BASE_W'(run_first);
				r.run_length = run_size;
				run_active = 1'b0;
				run_first = '0;
				run_size = '0;
			end
			chunk_pos = '0;
			chunk_dirty = 1'b0;
		end else begin
			chunk_pos = POS_W'(count);
		end
		if (w.final_byte) begin
			if (run_active) begin
				emit = 1'b1;
				r.run_start = base_q + BASE_W'(run_first);
				r.run_length = run_size;
			end
			byte_off = '0;
			chunk_pos = '0;
			chunk_dirty = 1'b0;
			run_active = 1'b0;
			run_first = '0;
			run_size = '0;
		end
		if (emit)
			expected_runs.insert(expected_runs.size(), r);
	endtask

	always @(posedge clk) begin
		cdrf_pkg::out_word_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					cdrf_pkg::CFG_CHUNK_SIZE: chunk_size_q = cfg_data[SIZE_W-1:0];
					cdrf_pkg::CFG_REGION_BASE: base_q = cfg_data[BASE_W-1:0];
					cdrf_pkg::CFG_MATCH_MODE: match_q = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				take_byte(in_data);
				bytes_left--;
			end
			if (out_valid && out_ready) begin
				if (expected_runs.size() == 0) begin
					report($sformatf("run start %h length %h with no run pending",
						out_data.run_start, out_data.run_length));
				end else begin
					want = expected_runs.pop_front();
					if (out_data.run_start !== want.run_start)
						report($sformatf("run_start %h, wanted %h",
							out_data.run_start, want.run_start));
					if (out_data.run_length !== want.run_length)
						report($sformatf("run_length %h, wanted %h",
							out_data.run_length, want.run_length));
				end
			end
		end
	end

	int burst_left = 0;
	int gap_left = 0;

	always @(posedge clk) begin
		if (arst_n && (!in_valid || in_ready)) begin
			if (gap_left > 0) begin
				gap_left = gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_bytes.size() > 0) begin
				in_data <= pending_bytes.pop_front();
				in_valid <= 1'b1;
				if (burst_left > 1) begin
					burst_left = burst_left - 1;
				end else begin
					burst_left = $urandom_range(1, 24);
					if ($urandom_range(0, 3) == 0)
						gap_left = 0;
					else if ($urandom_range(0, 9) == 0)
						gap_left = $urandom_range(5, 30);
					else
						gap_left = $urandom_range(1, 4);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	int stall_left = 0;
	stall_kind_t stall_kind = STALL_NONE;

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_kind = stall_kind_t'($urandom_range(0, 3));
			stall_left = $urandom_range(5, 60);
		end else begin
			stall_left = stall_left - 1;
		end
		case (stall_kind)
			STALL_NONE: out_ready <= 1'b1;
			STALL_HALF: out_ready <= 1'($urandom_range(0, 1));
			STALL_RARE: out_ready <= ($urandom_range(0, 7) != 0);
			default: out_ready <= 1'b0;
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)
				|| (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench failed");
			$finish;
		end
	end

	task automatic queue_byte(input logic [7:0] a, input logic [7:0] b, input logic last);
		cdrf_pkg::in_word_t w;
		w.first_byte = a;
		w.second_byte = b;
		w.final_byte = last;
		pending_bytes.insert(pending_bytes.size(), w);
		bytes_left++;
		bytes_queued++;
	endtask

	task automatic settle();
		while (bytes_left != 0 || expected_runs.size() != 0)
			@(posedge clk);
		repeat (PIPE_DRAIN) @(posedge clk);
	endtask

	task automatic write_reg(input logic [IDX_W-1:0] idx,
			input logic [DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do
			@(posedge clk);
		while (!(cfg_valid && cfg_ready));
	endtask

	task automatic configure(input logic [DATA_W-1:0] size_word,
			input logic [DATA_W-1:0] base_word,
			input logic [DATA_W-1:0] mode_word);
		settle();
		write_reg(cdrf_pkg::CFG_CHUNK_SIZE, size_word);
		write_reg(cdrf_pkg::CFG_REGION_BASE, base_word);
		write_reg(cdrf_pkg::CFG_MATCH_MODE, mode_word);
		cfg_valid <= 1'b0;
	endtask

	task automatic queue_snapshot(input int len, input int cs);
		chunk_pattern_t kind;
		int mark;
		logic [7:0] a;
		logic [7:0] b;
		logic same;
		kind = chunk_pattern_t'($urandom_range(0, 3));
		mark = 0;
		for (int i = 0; i < len; i++) begin
			if (i % cs == 0) begin
				if ($urandom_range(0, 9) < 4)
					kind = chunk_pattern_t'($urandom_range(0, 3));
				mark = $urandom_range(0, cs - 1);
			end
			case (kind)
				CHUNK_SAME: same = 1'b1;
				CHUNK_ONE_DIFF: same = (i % cs) != mark;
				CHUNK_MIXED: same = 1'($urandom_range(0, 1));
				default: same = 1'b0;
			endcase
			a = 8'($urandom);
			b = same ? a : a ^ 8'($urandom_range(1, 255));
			queue_byte(a, b, i == len - 1);
		end
	endtask

	initial begin
		logic [DATA_W-1:0] size_word;
		logic [DATA_W-1:0] base_word;
		logic [DATA_W-1:0] mode_word;
		int cs_eff;
		int len;
		int pick;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Values after reset: chunks of 4096 bytes, changed chunks reported.
		queue_byte(8'h00, 8'h00, 1'b0);
		queue_byte(8'hFF, 8'h00, 1'b0);
		queue_byte(8'hA5, 8'hA5, 1'b1);
		queue_byte(8'h5A, 8'h5A, 1'b1);
		queue_byte(8'h00, 8'hFF, 1'b1);

		// A chunk size of zero acts as one, and the start address wraps.
		configure('0, '1, '0);
		queue_byte(8'h12, 8'h34, 1'b0);
		queue_byte(8'hFF, 8'hFF, 1'b0);
		queue_byte(8'h01, 8'h80, 1'b0);
		queue_byte(8'h77, 8'h76, 1'b1);

		// An oversized chunk is clamped, and unchanged chunks are reported.
		configure('1, 48'h1234_5678_9ABC, '1);
		queue_byte(8'hFF, 8'hFF, 1'b0);
		queue_byte(8'h00, 8'h00, 1'b0);
		queue_byte(8'h80, 8'h80, 1'b0);
		queue_byte(8'h7F, 8'h7F, 1'b1);
		queue_byte(8'hAA, 8'h55, 1'b0);
		queue_byte(8'h3C, 8'h3C, 1'b1);

		// A length that is a whole number of chunks forms no empty chunk.
		configure(48'd2, 48'hFFFF_FFFF_FFF0, '0);
		queue_byte(8'h01, 8'h02, 1'b0);
		queue_byte(8'h10, 8'h20, 1'b0);
		queue_byte(8'h44, 8'h44, 1'b0);
		queue_byte(8'hFE, 8'hEF, 1'b1);

		configure(48'd1, '0, 48'd1);
		queue_byte(8'h99, 8'h99, 1'b0);
		queue_byte(8'h0F, 8'hF0, 1'b0);
		queue_byte(8'hC3, 8'hC3, 1'b1);

		while (bytes_queued < TARGET_BYTES) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				size_word = '0;
			else if (pick == 1)
				size_word = DATA_W'(cdrf_pkg::CHUNK_MAX);
			else if (pick == 2)
				size_word = DATA_W'($urandom_range(16777217, 33554431));
			else if (pick < 6)
				size_word = DATA_W'($urandom_range(9, 16));
			else
				size_word = DATA_W'($urandom_range(1, 8));
			if (size_word == '0)
				cs_eff = 1;
			else if (size_word > DATA_W'(cdrf_pkg::CHUNK_MAX))
				cs_eff = int'(cdrf_pkg::CHUNK_MAX);
			else
				cs_eff = int'(size_word[SIZE_W-1:0]);
			if ($urandom_range(0, 3) == 0)
				size_word[DATA_W-1:SIZE_W] = (DATA_W - SIZE_W)'($urandom);
			pick = $urandom_range(0, 7);
			if (pick == 0)
				base_word = '0;
			else if (pick == 1)
				base_word = '1;
			else
				base_word = DATA_W'({$urandom, $urandom});
			mode_word = DATA_W'($urandom_range(0, 1));
			if ($urandom_range(0, 3) == 0)
				mode_word[DATA_W-1:1] = (DATA_W - 1)'({$urandom, $urandom});
			configure(size_word, base_word, mode_word);
			repeat ($urandom_range(1, 4)) begin
				if (cs_eff > 16) begin
					len = $urandom_range(1, 40);
				end else begin
					len = $urandom_range(1, 10) * cs_eff;
					if ($urandom_range(0, 2) == 0)
						len += $urandom_range(1, cs_eff);
					if ($urandom_range(0, 15) == 0)
						len = 1;
				end
				queue_snapshot(len, cs_eff);
			end
		end

		settle();
		if (expected_runs.size() != 0)
			report($sformatf("%0d runs never arrived", expected_runs.size()));
		if (mismatches == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
